@@ hw/rtl/diff_hunk_header_parser_defines.svh @@
// ----------------------------------------------------------------------------
// diff hunk header parser assertion macros
// concurrent assertion helpers, sampled on clk_i, off while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef DIFF_HUNK_HEADER_PARSER_DEFINES_SVH
`define DIFF_HUNK_HEADER_PARSER_DEFINES_SVH

// same-cycle implication
`define DHHP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dhhp assertion failed");

// next-cycle implication
`define DHHP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dhhp assertion failed");

`endif

@@ hw/rtl/dhhp_pkg.sv @@
// ----------------------------------------------------------------------------
// dhhp_pkg
// types and constants of the normal diff hunk header parser
// ----------------------------------------------------------------------------
package dhhp_pkg;

  localparam int unsigned MAX_HEADER_CHARS = 99;
  localparam int unsigned LINE_BITS        = 31;

  localparam logic [31:0] OUT_MAX = 32'h7FFF_FFFF;

  localparam logic REQ_BYTE  = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_NUL   = 8'd0;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_A     = 8'h61;
  localparam logic [7:0] CHAR_C     = 8'h63;
  localparam logic [7:0] CHAR_D     = 8'h64;

  // parser phase, one-hot
  typedef enum logic [5:0] {
    PH_S1   = 6'b000001,
    PH_E1   = 6'b000010,
    PH_S2   = 6'b000100,
    PH_E2   = 6'b001000,
    PH_BAD  = 6'b010000,
    PH_HELD = 6'b100000
  } phase_e;

  typedef enum logic [1:0] {
    MODE_A = 2'd0,
    MODE_C = 2'd1,
    MODE_D = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_CHANGE = 2'd1,
    KIND_DELETE = 2'd2
  } kind_e;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
  } req_t;

  typedef struct packed {
    logic [1:0]         mark_kind;
    logic signed [31:0] first_line;
    logic signed [31:0] last_line;
  } mark_t;

endpackage

@@ hw/rtl/diff_hunk_header_parser.sv @@
// ----------------------------------------------------------------------------
// diff_hunk_header_parser
// on-the-fly parser of normal diff hunk headers into line marks
// ----------------------------------------------------------------------------
// Bytes of normal-format diff output enter one per transfer on the input
// channel. A line whose first byte is a digit is parsed as s1[,e1]{a|c|d}s2[,e2]
// while it streams in; at CR/LF, or on a flush transfer, a well-formed header
// gives one line mark (append, change or delete plus a first/last line) on the
// output channel, chosen and offset by the editing_old_file register. Lines of
// MaxHeaderChars bytes or more, and malformed lines, give nothing. Numbers
// saturate at 2^LineBits-1 and output lines at 2^31-1. The block takes one
// transfer every cycle unless held off; a mark is valid on the output the
// cycle after the byte that ends its line. The per-byte update (digit test,
// saturating multiply-by-ten accumulate, phase step) is combinational logic
// on the parser state, which is what bounds the clock. While a mark waits in
// the output register and the receiver is not ready, the input is held off;
// when that mark makes its transfer, a new byte is taken in the same cycle.
`include "diff_hunk_header_parser_defines.svh"

module diff_hunk_header_parser #(
  parameter int unsigned MaxHeaderChars = dhhp_pkg::MAX_HEADER_CHARS,
  parameter int unsigned LineBits       = dhhp_pkg::LINE_BITS
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  // configuration
  input  logic           cfg_we_i,
  input  logic           cfg_wdata_i,
  // byte stream in
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  dhhp_pkg::req_t in_data_i,
  // line marks out
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output dhhp_pkg::mark_t out_data_o
);
  import dhhp_pkg::*;

  localparam int unsigned CntW = $clog2(MaxHeaderChars + 1);
  localparam int unsigned AccW = LineBits + 4;
  localparam int unsigned CmpW = (LineBits > 32) ? LineBits : 32;
  localparam logic [LineBits-1:0] LineMax = '1;

  // saturating v*10 + d
  function automatic logic [LineBits-1:0] mac10(logic [LineBits-1:0] v, logic [3:0] d);
    logic [AccW-1:0] p;
    p = (AccW'(v) << 3) + (AccW'(v) << 1) + AccW'(d);
    if (p > AccW'(LineMax)) begin
      return LineMax;
    end
    return p[LineBits-1:0];
  endfunction

  // optional minus one, then clamp to the 32-bit signed output range
  function automatic logic [31:0] line_out(logic [LineBits-1:0] v, logic sub);
    logic [LineBits-1:0] w;
    logic [CmpW-1:0]     wx;
    logic [31:0]         r;
    w  = v - LineBits'(sub);
    wx = CmpW'(w);
    if (sub && (v == '0)) begin
      r = '1;
    end else if (wx > CmpW'(OUT_MAX)) begin
      r = OUT_MAX;
    end else begin
      r = wx[31:0];
    end
    return r;
  endfunction

  // configuration register
  logic editing_old_file_q;

  // parser state
  logic                at_line_head_q, at_line_head_d;
  logic                collecting_q, collecting_d;
  logic [CntW-1:0]     char_count_q, char_count_d;
  phase_e              phase_q, phase_d;
  mode_e               mode_q, mode_d;
  logic [LineBits-1:0] old_start_q, old_start_d;
  logic [LineBits-1:0] old_end_q, old_end_d;
  logic [LineBits-1:0] new_start_q, new_start_d;
  logic [LineBits-1:0] new_end_q, new_end_d;

  // output register
  logic  out_valid_q, out_valid_d;
  mark_t out_data_q, out_data_d;

  logic                in_fire;
  logic [7:0]          c;
  logic                is_eol, is_dig, is_mode;
  mode_e               byte_mode;
  logic [LineBits-1:0] mac_src, mac_res;
  logic [CntW-1:0]     count_inc;
  logic                fin_ok, emit;
  logic [LineBits-1:0] fin_new_end, fin_first, fin_last;
  logic                fin_sub;
  kind_e               fin_kind;
  mark_t               fin_mark;

  // output slot free, or being emptied this cycle
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // byte classification
  assign c      = in_data_i.data_byte;
  assign is_eol = (c == CHAR_LF) || (c == CHAR_CR);
  assign is_dig = (c >= CHAR_ZERO) && (c <= CHAR_NINE);

  always_comb begin
    is_mode   = 1'b1;
    byte_mode = MODE_A;
    unique case (c)
      CHAR_A:  byte_mode = MODE_A;
      CHAR_C:  byte_mode = MODE_C;
      CHAR_D:  byte_mode = MODE_D;
      default: is_mode = 1'b0;
    endcase
  end

  // one shared accumulator, fed with the number of the current phase
  always_comb begin
    unique case (phase_q)
      PH_E1:   mac_src = old_end_q;
      PH_S2:   mac_src = new_start_q;
      PH_E2:   mac_src = new_end_q;
      default: mac_src = old_start_q;
    endcase
  end
  assign mac_res = mac10(mac_src, c[3:0]);

  assign count_inc = char_count_q + CntW'(1);

  // mark for the header collected so far; empty second end means e2 = s2
  assign fin_ok      = (phase_q == PH_S2) || (phase_q == PH_E2) || (phase_q == PH_HELD);
  assign fin_new_end = (phase_q == PH_S2) ? new_start_q : new_end_q;

  always_comb begin
    if (editing_old_file_q) begin
      fin_first = old_start_q;
      fin_last  = old_end_q;
      if (mode_q == MODE_A) begin
        fin_kind = KIND_DELETE;
        fin_sub  = 1'b0;
      end else begin
        fin_kind = (mode_q == MODE_C) ? KIND_CHANGE : KIND_APPEND;
        fin_sub  = 1'b1;
      end
    end else begin
      fin_first = new_start_q;
      fin_last  = fin_new_end;
      if (mode_q == MODE_D) begin
        fin_kind = KIND_DELETE;
        fin_sub  = 1'b0;
      end else begin
        fin_kind = (mode_q == MODE_C) ? KIND_CHANGE : KIND_APPEND;
        fin_sub  = 1'b1;
      end
    end
    fin_mark.mark_kind  = fin_kind;
    fin_mark.first_line = $signed(line_out(fin_first, fin_sub));
    fin_mark.last_line  = $signed(line_out(fin_last, fin_sub));
  end

  // parser next state
  always_comb begin
    at_line_head_d = at_line_head_q;
    collecting_d   = collecting_q;
    char_count_d   = char_count_q;
    phase_d        = phase_q;
    mode_d         = mode_q;
    old_start_d    = old_start_q;
    old_end_d      = old_end_q;
    new_start_d    = new_start_q;
    new_end_d      = new_end_q;
    emit           = 1'b0;

    if (in_fire) begin
      if (in_data_i.req_type == REQ_FLUSH) begin
        // end of output: evaluate pending header, back to line head
        emit           = collecting_q && fin_ok;
        at_line_head_d = 1'b1;
        collecting_d   = 1'b0;
        char_count_d   = '0;
        phase_d        = PH_S1;
      end else if (at_line_head_q) begin
        // blank line bytes are skipped, a digit opens a header
        if (!is_eol) begin
          at_line_head_d = 1'b0;
          if (is_dig) begin
            collecting_d = 1'b1;
            char_count_d = CntW'(1);
            phase_d      = PH_S1;
            mode_d       = MODE_A;
            old_start_d  = LineBits'(c[3:0]);
            old_end_d    = '0;
            new_start_d  = '0;
            new_end_d    = '0;
          end
        end
      end else if (is_eol) begin
        emit           = collecting_q && fin_ok;
        at_line_head_d = 1'b1;
        collecting_d   = 1'b0;
        char_count_d   = '0;
        phase_d        = PH_S1;
      end else if (collecting_q) begin
        if (c == CHAR_NUL) begin
          // nul ends the header text
          if (phase_q == PH_S2) begin
            new_end_d = new_start_q;
            phase_d   = PH_HELD;
          end else if (phase_q == PH_E2) begin
            phase_d = PH_HELD;
          end else if (phase_q != PH_HELD) begin
            phase_d = PH_BAD;
          end
        end else begin
          unique case (phase_q)
            PH_S1: begin
              if (c == CHAR_COMMA) begin
                old_end_d = '0;
                phase_d   = PH_E1;
              end else if (is_mode) begin
                old_end_d   = old_start_q;
                mode_d      = byte_mode;
                new_start_d = '0;
                phase_d     = PH_S2;
              end else if (is_dig) begin
                old_start_d = mac_res;
              end else begin
                phase_d = PH_BAD;
              end
            end
            PH_E1: begin
              if (is_mode) begin
                mode_d      = byte_mode;
                new_start_d = '0;
                phase_d     = PH_S2;
              end else if (is_dig) begin
                old_end_d = mac_res;
              end else begin
                phase_d = PH_BAD;
              end
            end
            PH_S2: begin
              if (c == CHAR_COMMA) begin
                new_end_d = '0;
                phase_d   = PH_E2;
              end else if (is_dig) begin
                new_start_d = mac_res;
              end else begin
                phase_d = PH_BAD;
              end
            end
            PH_E2: begin
              if (is_dig) begin
                new_end_d = mac_res;
              end else begin
                phase_d = PH_BAD;
              end
            end
            PH_HELD: begin
              phase_d = PH_HELD;
            end
            default: begin
              phase_d = PH_BAD;
            end
          endcase
        end

        // length limit: drop the line, rest of it ignored
        if (count_inc >= CntW'(MaxHeaderChars)) begin
          collecting_d = 1'b0;
          char_count_d = '0;
          phase_d      = PH_S1;
        end else begin
          char_count_d = count_inc;
        end
      end
    end
  end

  // output register next state
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (in_fire && emit) begin
      out_valid_d = 1'b1;
      out_data_d  = fin_mark;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      editing_old_file_q <= 1'b0;
      at_line_head_q     <= 1'b1;
      collecting_q       <= 1'b0;
      char_count_q       <= '0;
      phase_q            <= PH_S1;
      mode_q             <= MODE_A;
      old_start_q        <= '0;
      old_end_q          <= '0;
      new_start_q        <= '0;
      new_end_q          <= '0;
      out_valid_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        editing_old_file_q <= cfg_wdata_i;
      end
      at_line_head_q <= at_line_head_d;
      collecting_q   <= collecting_d;
      char_count_q   <= char_count_d;
      phase_q        <= phase_d;
      mode_q         <= mode_d;
      old_start_q    <= old_start_d;
      old_end_q      <= old_end_d;
      new_start_q    <= new_start_d;
      new_end_q      <= new_end_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // a header is only ever collected past the line head
  `DHHP_ASSERT_IMP(a_collect_not_head, collecting_q, !at_line_head_q)
  // collected length stays within the limit
  `DHHP_ASSERT_IMP(a_count_range, collecting_q,
                   (char_count_q != '0) && (char_count_q < CntW'(MaxHeaderChars)))
  // a finished header shows up on the output in the next cycle
  `DHHP_ASSERT_NXT(a_mark_lands, in_fire && emit,
                   out_valid_o && (out_data_o == $past(fin_mark)))

endmodule
